// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the cache table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   `ASSERT_CLK(lbl, clk, rst, !(cond))

`endif

// ===== rtl/lacc_pkg.sv =====
package lacc_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int KEY_W       = 64;
   localparam int VALUE_W     = 32;
   localparam int STAMP_W     = 32;
   localparam int SLOT_W      = 4;
   localparam int RSP_DATA_W  = 40;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_WAIT
   } ctl_state_type;

   // Search token walked down the row of slot cells
   typedef struct packed {
      logic               active;
      logic               cmd;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               found;
      logic               free_found;
      logic [VALUE_W-1:0] match_value;
      logic [STAMP_W-1:0] best_stamp;
   } scan_token_type;

   // Write-back broadcast to all cells
   typedef struct packed {
      logic               en;
      logic               fill;
      logic [STAMP_W-1:0] stamp;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } cell_wr_type;

endpackage

// ===== rtl/lacc_cell.sv =====
module lacc_cell #(
   parameter int IDX_W = 4,
   parameter int IDX   = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lacc_pkg::scan_token_type prev_tok,
   input  logic [IDX_W-1:0]         prev_match_idx,
   input  logic [IDX_W-1:0]         prev_free_idx,
   input  logic [IDX_W-1:0]         prev_best_idx,
   output lacc_pkg::scan_token_type next_tok,
   output logic [IDX_W-1:0]         next_match_idx,
   output logic [IDX_W-1:0]         next_free_idx,
   output logic [IDX_W-1:0]         next_best_idx,
   input  lacc_pkg::cell_wr_type    wr,
   input  logic [IDX_W-1:0]         wr_idx
);

   localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(IDX);
   localparam bit               IS_FIRST = (IDX == 0);

   logic                              valid_ff;
   logic [lacc_pkg::STAMP_W-1:0]      stamp_ff;
   logic [lacc_pkg::KEY_W-1:0]        key_ff;
   logic [lacc_pkg::VALUE_W-1:0]      value_ff;
   lacc_pkg::scan_token_type          tok_ff, tok_in;
   logic [IDX_W-1:0]                  match_idx_ff, match_idx_in;
   logic [IDX_W-1:0]                  free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]                  best_idx_ff, best_idx_in;
   logic                              wr_sel;

   assign wr_sel = wr.en && (wr_idx == MY_IDX);

   always_comb begin
      tok_in       = prev_tok;
      match_idx_in = prev_match_idx;
      free_idx_in  = prev_free_idx;
      best_idx_in  = prev_best_idx;
      // first matching valid slot wins
      if (!prev_tok.found && valid_ff && (key_ff == prev_tok.key)) begin
         tok_in.found       = 1'b1;
         tok_in.match_value = value_ff;
         match_idx_in       = MY_IDX;
      end
      if (!prev_tok.free_found && !valid_ff) begin
         tok_in.free_found = 1'b1;
         free_idx_in       = MY_IDX;
      end
      // strict less-than keeps the lowest index on ties
      if (IS_FIRST || (stamp_ff < prev_tok.best_stamp)) begin
         tok_in.best_stamp = stamp_ff;
         best_idx_in       = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
      end else if (wr_sel) begin
         stamp_ff <= wr.stamp;
         if (wr.fill) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel && wr.fill) begin
         key_ff   <= wr.key;
         value_ff <= wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff       <= tok_in;
         match_idx_ff <= match_idx_in;
         free_idx_ff  <= free_idx_in;
         best_idx_ff  <= best_idx_in;
      end
   end

   assign next_tok       = tok_ff;
   assign next_match_idx = match_idx_ff;
   assign next_free_idx  = free_idx_ff;
   assign next_best_idx  = best_idx_ff;

endmodule

// ===== rtl/lru_assoc_cache_table.sv =====
// Fully associative cache of ENTRIES slots with least-recently-used
// replacement by age stamps. A lookup (tuser 0) returns the value of the
// lowest-index valid slot holding the key and restamps it; an insert (tuser 1)
// fills the lowest-index empty slot, else the slot with the smallest stamp,
// without checking for an existing copy of the key. One transaction is in
// flight at a time: the request travels as a token through a row of ENTRIES
// slot cells, one cell per cycle, and the result is written back to the
// chosen slot from the last cell's output register. A finished result waits
// in an output register while the next request is accepted. Valid bits and
// stamps clear at reset with no further start-up delay.
`include "assert_macros.svh"

module lru_assoc_cache_table #(
   parameter int ENTRIES = lacc_pkg::ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // key [63:0], value [95:64]
   input  logic [95:0]                       req_tdata,
   // command
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // data_out [31:0], slot [35:32], zero [39:36]
   output logic [lacc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // hit
   output logic                              rsp_tuser
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   lacc_pkg::scan_token_type     tok_chain   [ENTRIES+1];
   logic [IDX_W-1:0]             match_chain [ENTRIES+1];
   logic [IDX_W-1:0]             free_chain  [ENTRIES+1];
   logic [IDX_W-1:0]             best_chain  [ENTRIES+1];
   lacc_pkg::scan_token_type     head_tok;
   lacc_pkg::scan_token_type     last_tok;
   lacc_pkg::cell_wr_type        wr;
   logic [IDX_W-1:0]             wr_idx;

   lacc_pkg::ctl_state_type      state_ff, state_in;
   logic [lacc_pkg::STAMP_W-1:0] use_counter_ff, use_counter_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [lacc_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [lacc_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                         pend_hit_ff, pend_hit_in;
   logic [lacc_pkg::VALUE_W-1:0] pend_data_ff, pend_data_in;
   logic [lacc_pkg::SLOT_W-1:0]  pend_slot_ff, pend_slot_in;

   logic                         res_hit;
   logic [lacc_pkg::VALUE_W-1:0] res_data;
   logic [lacc_pkg::SLOT_W-1:0]  res_slot;
   logic                         is_insert;
   logic                         rsp_free;
   logic                         req_accept;

   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      head_tok             = '0;
      head_tok.active      = req_accept;
      head_tok.cmd         = req_tuser;
      head_tok.key         = req_tdata[63:0];
      head_tok.value       = req_tdata[95:64];
   end

   assign tok_chain[0]   = head_tok;
   assign match_chain[0] = '0;
   assign free_chain[0]  = '0;
   assign best_chain[0]  = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lacc_cell #(
         .IDX_W (IDX_W),
         .IDX   (g)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .prev_tok       (tok_chain[g]),
         .prev_match_idx (match_chain[g]),
         .prev_free_idx  (free_chain[g]),
         .prev_best_idx  (best_chain[g]),
         .next_tok       (tok_chain[g+1]),
         .next_match_idx (match_chain[g+1]),
         .next_free_idx  (free_chain[g+1]),
         .next_best_idx  (best_chain[g+1]),
         .wr             (wr),
         .wr_idx         (wr_idx)
      );
   end

   assign last_tok  = tok_chain[ENTRIES];
   assign is_insert = (last_tok.cmd == lacc_pkg::CMD_INSERT);
   assign res_hit   = !is_insert && last_tok.found;
   assign res_data  = res_hit ? last_tok.match_value : '0;

   // Pick the slot to restamp or fill
   always_comb begin
      if (!is_insert) begin
         wr_idx = match_chain[ENTRIES];
      end else if (last_tok.free_found) begin
         wr_idx = free_chain[ENTRIES];
      end else begin
         wr_idx = best_chain[ENTRIES];
      end
   end

   assign res_slot = (res_hit || is_insert) ? lacc_pkg::SLOT_W'(wr_idx) : '0;

   always_comb begin
      wr.en    = last_tok.active && (res_hit || is_insert);
      wr.fill  = is_insert;
      wr.stamp = use_counter_ff + lacc_pkg::STAMP_W'(1);
      wr.key   = last_tok.key;
      wr.value = last_tok.value;
   end

   assign use_counter_in = wr.en ? wr.stamp : use_counter_ff;
   assign rsp_free       = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_slot_in  = rsp_slot_ff;
      pend_hit_in  = pend_hit_ff;
      pend_data_in = pend_data_ff;
      pend_slot_in = pend_slot_ff;
      case (state_ff)
         lacc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = lacc_pkg::ST_BUSY;
            end
         end
         lacc_pkg::ST_BUSY: begin
            if (last_tok.active) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = res_hit;
                  rsp_data_in  = res_data;
                  rsp_slot_in  = res_slot;
                  state_in     = lacc_pkg::ST_IDLE;
               end else begin
                  // output still occupied: park the result
                  pend_hit_in  = res_hit;
                  pend_data_in = res_data;
                  pend_slot_in = res_slot;
                  state_in     = lacc_pkg::ST_WAIT;
               end
            end
         end
         lacc_pkg::ST_WAIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = pend_hit_ff;
               rsp_data_in  = pend_data_ff;
               rsp_slot_in  = pend_slot_ff;
               state_in     = lacc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lacc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lacc_pkg::ST_IDLE;
         use_counter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         use_counter_ff <= use_counter_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_slot_ff  <= rsp_slot_in;
      pend_hit_ff  <= pend_hit_in;
      pend_data_ff <= pend_data_in;
      pend_slot_ff <= pend_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {(lacc_pkg::RSP_DATA_W - lacc_pkg::SLOT_W - lacc_pkg::VALUE_W)'(0),
                        rsp_slot_ff, rsp_data_ff};

   `ASSERT_CLK(a_accept_starts_scan, clock, reset, req_accept |=> state_ff == lacc_pkg::ST_BUSY)
   `ASSERT_NEVER(a_token_only_busy, clock, reset, last_tok.active && state_ff != lacc_pkg::ST_BUSY)
   `ASSERT_CLK(a_wait_output_full, clock, reset, state_ff == lacc_pkg::ST_WAIT |-> rsp_valid_ff)
   `ASSERT_CLK(a_miss_zero_data, clock, reset, rsp_valid_ff && !rsp_hit_ff |-> rsp_data_ff == '0)

endmodule

// ===== verif/tb_lru_assoc_cache_table.sv =====
`timescale 1ns / 100ps

module tb_lru_assoc_cache_table;
   import lacc_pkg::*;

   localparam int NUM_SLOTS  = ENTRIES_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int KEY_POOL   = 24;
   localparam int PER_PHASE  = 250;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] data_out;
      logic [SLOT_W-1:0]  slot;
   } cache_rsp_type;

   typedef struct packed {
      logic               cmd;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               typed;
      cache_rsp_type      rsp;
   } dir_row_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [KEY_W+VALUE_W-1:0]   req_tdata = '0;
   logic                       req_tuser = CMD_LOOKUP;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]      rsp_tdata;
   logic                       rsp_tuser;

   // Shadow copy of the cache contents
   logic                       shadow_valid [NUM_SLOTS];
   logic [KEY_W-1:0]           shadow_key   [NUM_SLOTS];
   logic [VALUE_W-1:0]         shadow_value [NUM_SLOTS];
   logic [STAMP_W-1:0]         shadow_stamp [NUM_SLOTS];
   logic [STAMP_W-1:0]         shadow_use_count;

   cache_rsp_type              pending_rsps [$];
   int                         err_count  = 0;
   int                         idle_pct   = 0;
   int                         stall_pct  = 0;
   int                         quiet_cycles = 0;
   logic [KEY_W-1:0]           key_pool [KEY_POOL];
   int                         idle_by_phase  [4] = '{0, 73, 0, 13};
   int                         stall_by_phase [4] = '{0, 0, 73, 13};

   localparam logic [KEY_W-1:0]   KEY_ONES = {KEY_W{1'b1}};
   localparam logic [VALUE_W-1:0] VAL_ONES = {VALUE_W{1'b1}};

   dir_row_type dir_rows [25] = '{
      '{CMD_LOOKUP, 64'h0,    32'h0,        1'b1, '{1'b0, 32'h0,     4'd0}},
      '{CMD_LOOKUP, KEY_ONES, 32'h0,        1'b1, '{1'b0, 32'h0,     4'd0}},
      '{CMD_INSERT, 64'h0,    VAL_ONES,     1'b1, '{1'b0, 32'h0,     4'd0}},
      '{CMD_INSERT, KEY_ONES, 32'h0,        1'b1, '{1'b0, 32'h0,     4'd1}},
      '{CMD_LOOKUP, 64'h0,    32'h0,        1'b1, '{1'b1, VAL_ONES,  4'd0}},
      '{CMD_LOOKUP, KEY_ONES, VAL_ONES,     1'b1, '{1'b1, 32'h0,     4'd1}},
      // same key again: a second copy lands in the next free slot
      '{CMD_INSERT, KEY_ONES, 32'h1234_5678, 1'b1, '{1'b0, 32'h0,    4'd2}},
      '{CMD_LOOKUP, KEY_ONES, 32'h0,        1'b1, '{1'b1, 32'h0,     4'd1}},
      '{CMD_LOOKUP, 64'h5,    VAL_ONES,     1'b1, '{1'b0, 32'h0,     4'd0}},
      '{CMD_INSERT, 64'h100,  32'hA000_0003, 1'b1, '{1'b0, 32'h0,    4'd3}},
      '{CMD_INSERT, 64'h101,  32'hA000_0004, 1'b1, '{1'b0, 32'h0,    4'd4}},
      '{CMD_INSERT, 64'h102,  32'hA000_0005, 1'b1, '{1'b0, 32'h0,    4'd5}},
      '{CMD_INSERT, 64'h103,  32'hA000_0006, 1'b1, '{1'b0, 32'h0,    4'd6}},
      '{CMD_INSERT, 64'h104,  32'hA000_0007, 1'b1, '{1'b0, 32'h0,    4'd7}},
      '{CMD_INSERT, 64'h105,  32'hA000_0008, 1'b1, '{1'b0, 32'h0,    4'd8}},
      '{CMD_INSERT, 64'h106,  32'hA000_0009, 1'b1, '{1'b0, 32'h0,    4'd9}},
      '{CMD_INSERT, 64'h107,  32'hA000_000A, 1'b1, '{1'b0, 32'h0,    4'd10}},
      '{CMD_INSERT, 64'h108,  32'hA000_000B, 1'b1, '{1'b0, 32'h0,    4'd11}},
      '{CMD_INSERT, 64'h109,  32'hA000_000C, 1'b1, '{1'b0, 32'h0,    4'd12}},
      '{CMD_INSERT, 64'h10A,  32'hA000_000D, 1'b1, '{1'b0, 32'h0,    4'd13}},
      '{CMD_INSERT, 64'h10B,  32'hA000_000E, 1'b1, '{1'b0, 32'h0,    4'd14}},
      '{CMD_INSERT, 64'h10C,  32'hA000_000F, 1'b1, '{1'b0, 32'h0,    4'd15}},
      // table full: evict by oldest stamp
      '{CMD_INSERT, 64'h0123_4567_89AB_CDEF, 32'h5A5A_5A5A, 1'b0, '{1'b0, 32'h0, 4'd0}},
      '{CMD_LOOKUP, 64'h0,    32'h0,        1'b0, '{1'b0, 32'h0,     4'd0}},
      '{CMD_INSERT, 64'hFEDC_BA98_7654_3210, 32'hC3C3_C3C3, 1'b0, '{1'b0, 32'h0, 4'd0}}
   };

   lru_assoc_cache_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // Apply one cache access to the shadow copy and return its response
   function automatic cache_rsp_type cache_access(input logic cmd,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VALUE_W-1:0] value);
      cache_rsp_type      rsp;
      int                 victim;
      bit                 free_seen;
      logic [STAMP_W-1:0] oldest;
      rsp = '0;
      victim = 0;
      free_seen = 1'b0;
      if (cmd == CMD_LOOKUP) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (shadow_valid[i] && shadow_key[i] == key) begin
               shadow_use_count = shadow_use_count + 1'b1;
               shadow_stamp[i]  = shadow_use_count;
               rsp.hit      = 1'b1;
               rsp.data_out = shadow_value[i];
               rsp.slot     = SLOT_W'(i);
               break;
            end
         end
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!free_seen && !shadow_valid[i]) begin
               victim    = i;
               free_seen = 1'b1;
            end
         end
         if (!free_seen) begin
            oldest = shadow_stamp[0];
            for (int i = 1; i < NUM_SLOTS; i++) begin
               // strict compare keeps the lowest index on ties
               if (shadow_stamp[i] < oldest) begin
                  oldest = shadow_stamp[i];
                  victim = i;
               end
            end
         end
         shadow_use_count     = shadow_use_count + 1'b1;
         shadow_stamp[victim] = shadow_use_count;
         shadow_valid[victim] = 1'b1;
         shadow_key[victim]   = key;
         shadow_value[victim] = value;
         rsp.slot = SLOT_W'(victim);
      end
      return rsp;
   endfunction

   task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value, input logic typed,
                               input cache_rsp_type fixed);
      cache_rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {value, key};
      do @(posedge clock); while (!req_tready);
      predicted = cache_access(cmd, key, value);
      pending_rsps.push_back(typed ? fixed : predicted);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      cache_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("response with nothing outstanding", 64'(rsp_tdata), 64'h0);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_tuser !== want.hit)
               report_mismatch("hit", 64'(rsp_tuser), 64'(want.hit));
            if (rsp_tdata[31:0] !== want.data_out)
               report_mismatch("data_out", 64'(rsp_tdata[31:0]), 64'(want.data_out));
            if (rsp_tdata[35:32] !== want.slot)
               report_mismatch("slot", 64'(rsp_tdata[35:32]), 64'(want.slot));
            if (rsp_tdata[39:36] !== 4'h0)
               report_mismatch("tdata padding", 64'(rsp_tdata[39:36]), 64'h0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic             cmd;
      logic [KEY_W-1:0] key;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_stamp[i] = '0;
      end
      shadow_use_count = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].value,
                      dir_rows[i].typed, dir_rows[i].rsp);
      end

      // a small key pool keeps hits and evictions frequent
      key_pool[0] = '0;
      key_pool[1] = KEY_ONES;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_by_phase[ph];
         stall_pct = stall_by_phase[ph];
         repeat (PER_PHASE) begin
            cmd = ($urandom_range(99) < 40) ? CMD_INSERT : CMD_LOOKUP;
            if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
            else key = {$urandom, $urandom};
            send_request(cmd, key, $urandom, 1'b0, '0);
         end
      end

      req_tvalid = 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (2 * NUM_SLOTS + 8) @(posedge clock);
      if (err_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== lru_assoc_cache_table.f =====
+incdir+rtl
rtl/lacc_pkg.sv
rtl/lacc_cell.sv
rtl/lru_assoc_cache_table.sv
verif/tb_lru_assoc_cache_table.sv
